@@ hdl/rpn_pkg.sv @@
// Package for the RPN stack calculator: item types, opcodes, FSM states, divider request.
// No dependencies.
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_REM   = 4'd5,
        OP_SHOW  = 4'd6,
        OP_DUP   = 4'd7,
        OP_SWAP  = 4'd8,
        OP_CLEAR = 4'd9,
        OP_POP   = 4'd10
    } op_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] operand;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] shown_value;
        logic               shown_valid;
        logic [7:0]         depth;
        logic               empty_error;
        logic               overflow_error;
        logic               divide_error;
        logic               small_error;
        logic               unknown_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_EXEC,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic        start;
        logic        want_rem;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

endpackage

@@ hdl/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: control FSM, ALU and output register.
// Uses rpn_pkg, rpn_stack_ram and rpn_divider.
//
// One token at a time. A token passes through any reads of the single-read-port
// stack memory, whose data is registered, then execute, then one write per
// item pushed back, then hand-over of the result. Div and rem with a nonzero
// divisor also wait on the one-bit-per-cycle divider. The result sits in an
// output register; the next token is taken while it waits, and that token
// stalls before its hand-over until the register frees. Mul uses one 32x32
// multiplier followed by a register.
module rpn_stack_calculator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpn_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpn_pkg::out_item_t out_data
);

    localparam int AW = rpn_pkg::ADDR_W;
    localparam int PW = rpn_pkg::PTR_W;
    localparam logic [PW-1:0] FULL = PW'(rpn_pkg::STACK_DEPTH);

    rpn_pkg::state_t state_reg, state_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [3:0] op_reg;
    logic signed [31:0] operand_reg, a_reg, b_reg;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic signed [63:0] prod_reg;
    logic out_valid_reg;
    rpn_pkg::out_item_t out_reg, res_reg, res_next;
    logic signed [31:0] w0_reg, w1_reg, w0_next, w1_next;
    logic [1:0] nw_reg, nw_next;
    logic [1:0] wcnt_reg, wcnt_next;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata, rdata;
    logic [PW-1:0] pops;
    logic slot_free;
    rpn_pkg::div_req_t dreq;
    logic ddone;
    logic signed [31:0] dres;
    logic signed [32:0] sum33;
    logic [63:0] pmag;
    logic [47:0] mmag;
    logic signed [31:0] mulq;
    logic [PW-1:0] sp_base;
    logic signed [31:0] b_in, a_in;

    rpn_stack_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                         .raddr(raddr), .rdata(rdata));
    rpn_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .result(dres));

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == rpn_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        unique case (rpn_pkg::op_t'(op_reg))
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_SWAP,
            rpn_pkg::OP_DIV, rpn_pkg::OP_REM: pops = PW'(2);
            rpn_pkg::OP_SHOW, rpn_pkg::OP_DUP, rpn_pkg::OP_POP: pops = PW'(1);
            default: pops = '0;
        endcase
    end

    assign raddr = AW'(sp_reg - PW'(rd_cnt_reg) - PW'(1));
    assign dreq.start    = (state_reg == rpn_pkg::ST_DIV);
    assign dreq.want_rem = (op_reg == rpn_pkg::OP_REM);
    assign dreq.dividend = a_reg;
    assign dreq.divisor  = b_reg;

    always_comb
    begin
        sum33 = (op_reg == rpn_pkg::OP_SUB) ? ({a_reg[31], a_reg} - {b_reg[31], b_reg})
                                            : ({a_reg[31], a_reg} + {b_reg[31], b_reg});
        pmag = prod_reg[63] ? (~prod_reg + 64'd1) : prod_reg;
        mmag = pmag[63:16];
        if (prod_reg[63])
            mulq = (mmag > 48'h0000_8000_0000) ? 32'h8000_0000 : (~mmag[31:0] + 32'd1);
        else
            mulq = (mmag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mmag[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::ST_IDLE:  if (in_valid) state_next = rpn_pkg::ST_READ;
            rpn_pkg::ST_READ:  state_next = (pops == '0) ? rpn_pkg::ST_EXEC : rpn_pkg::ST_WAIT;
            rpn_pkg::ST_WAIT:
                if (rd_cnt_reg == 2'd1 && pops == PW'(2)) state_next = rpn_pkg::ST_WAIT;
                else state_next = rpn_pkg::ST_EXEC;
            rpn_pkg::ST_EXEC:
                if ((op_reg == rpn_pkg::OP_DIV || op_reg == rpn_pkg::OP_REM)
                    && b_reg != 32'd0)
                    state_next = rpn_pkg::ST_DIV;
                else state_next = rpn_pkg::ST_WRITE;
            rpn_pkg::ST_DIV:   if (ddone) state_next = rpn_pkg::ST_WRITE;
            rpn_pkg::ST_WRITE:
                if (wcnt_reg >= nw_reg && slot_free) state_next = rpn_pkg::ST_IDLE;
            default: state_next = rpn_pkg::ST_IDLE;
        endcase
    end

    // read counting, write-back plan set up once operands are in, and its stack writes
    always_comb
    begin
        sp_base = (sp_reg >= pops) ? sp_reg - pops : '0;
        res_next = res_reg;
        w0_next = w0_reg; w1_next = w1_reg; nw_next = nw_reg;
        rd_cnt_next = rd_cnt_reg;
        wcnt_next = wcnt_reg;
        sp_next = sp_reg;
        we = 1'b0; waddr = AW'(sp_reg); wdata = w0_reg;
        if (state_reg == rpn_pkg::ST_IDLE)
        begin
            rd_cnt_next = '0;
            wcnt_next = '0;
            nw_next = '0;
            res_next = '0;
        end
        if (state_reg == rpn_pkg::ST_READ)
            rd_cnt_next = rd_cnt_reg + 2'd1;
        if (state_reg == rpn_pkg::ST_WAIT && rd_cnt_reg == 2'd1 && pops == PW'(2))
            rd_cnt_next = 2'd2;
        if (state_reg == rpn_pkg::ST_WRITE && wcnt_reg < nw_reg)
        begin
            if (sp_reg < FULL)
            begin
                we = 1'b1;
                wdata = (wcnt_reg == 2'd0) ? w0_reg : w1_reg;
                sp_next = sp_reg + PW'(1);
            end
            else
                res_next.overflow_error = 1'b1;
            wcnt_next = wcnt_reg + 2'd1;
        end
        if (state_reg == rpn_pkg::ST_DIV && ddone)
        begin
            w0_next = dres; nw_next = 2'd1;
        end
        if (state_reg == rpn_pkg::ST_EXEC)
        begin
            sp_next = sp_reg;
            unique case (rpn_pkg::op_t'(op_reg))
                rpn_pkg::OP_PUSH: begin w0_next = operand_reg; nw_next = 2'd1; end
                rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
                rpn_pkg::OP_REM:
                begin
                    res_next.empty_error = (sp_reg < PW'(2));
                    if ((op_reg == rpn_pkg::OP_DIV || op_reg == rpn_pkg::OP_REM)
                        && b_reg == 32'd0)
                    begin
                        res_next.divide_error = 1'b1;
                        res_next.empty_error = (sp_reg == '0);
                        sp_next = (sp_reg != '0) ? sp_reg - PW'(1) : '0;
                    end
                    else
                    begin
                        sp_next = sp_base;
                        nw_next = (op_reg == rpn_pkg::OP_DIV || op_reg == rpn_pkg::OP_REM)
                                  ? 2'd0 : 2'd1;
                        w0_next = (op_reg == rpn_pkg::OP_MUL) ? mulq :
                                  (sum33[32] != sum33[31]) ?
                                  (sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum33[31:0];
                    end
                end
                rpn_pkg::OP_SHOW:
                    if (sp_reg == '0) res_next.empty_error = 1'b1;
                    else begin res_next.shown_value = b_reg; res_next.shown_valid = 1'b1; end
                rpn_pkg::OP_DUP:
                    if (sp_reg == '0) res_next.empty_error = 1'b1;
                    else begin sp_next = sp_base; w0_next = b_reg; w1_next = b_reg;
                        nw_next = 2'd2; end
                rpn_pkg::OP_SWAP:
                    if (sp_reg < PW'(2)) res_next.small_error = 1'b1;
                    else begin sp_next = sp_base; w0_next = b_reg; w1_next = a_reg;
                        nw_next = 2'd2; end
                rpn_pkg::OP_CLEAR: sp_next = '0;
                rpn_pkg::OP_POP:
                begin
                    res_next.shown_valid = 1'b1;
                    if (sp_reg == '0) res_next.empty_error = 1'b1;
                    else begin res_next.shown_value = b_reg; sp_next = sp_base; end
                end
                default: res_next.unknown_error = 1'b1;
            endcase
        end
        res_next.depth = 8'(sp_next);
    end

    // operands arrive in the cycle after their address
    always_comb
    begin
        b_in = b_reg; a_in = a_reg;
        if (state_reg == rpn_pkg::ST_WAIT && rd_cnt_reg == 2'd1) b_in = rdata;
        if (state_reg == rpn_pkg::ST_WAIT && rd_cnt_reg == 2'd2) a_in = rdata;
        if (state_reg == rpn_pkg::ST_WAIT && rd_cnt_reg == 2'd2 && sp_reg < PW'(2)) a_in = '0;
        if (state_reg == rpn_pkg::ST_WAIT && rd_cnt_reg == 2'd1 && sp_reg == '0) b_in = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::ST_IDLE;
            sp_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_cnt_reg <= '0;
            wcnt_reg <= '0;
            nw_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            rd_cnt_reg <= rd_cnt_next;
            wcnt_reg <= wcnt_next;
            nw_reg <= nw_next;
            if (state_reg == rpn_pkg::ST_WRITE && state_next == rpn_pkg::ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= in_data.op;
            operand_reg <= in_data.operand;
        end
        b_reg <= b_in;
        a_reg <= a_in;
        prod_reg <= a_in * b_in;
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        res_reg <= res_next;
        if (state_reg == rpn_pkg::ST_WRITE && state_next == rpn_pkg::ST_IDLE)
            out_reg <= res_next;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= FULL)
        else $error("stack pointer beyond depth");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (sp_reg < FULL))
        else $error("write past top of stack");

endmodule

@@ hdl/rpn_divider.sv @@
// Iterative signed divider, one quotient bit per cycle over 48 bits (32 for remainder).
// Gives saturated Q16.16 quotient or raw remainder. Uses rpn_pkg.
module rpn_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::div_req_t  req,
    output logic               done,
    output logic signed [31:0] result
);

    logic [47:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next, rem_mode_reg, rem_mode_next;
    logic [32:0] trial;
    logic [31:0] a_mag, b_mag;
    logic [47:0] qv;
    logic [31:0] rv;

    always_comb
    begin
        a_mag = req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
        b_mag = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
        trial = {rem_reg[31:0], quot_reg[47]} - {1'b0, dvs_reg};
        quot_next = quot_reg; rem_next = rem_reg; dvs_next = dvs_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg; rem_mode_next = rem_mode_reg;
        done = 1'b0;
        if (req.start && !busy_reg)
        begin
            quot_next = {a_mag, 16'd0};
            rem_next = '0;
            dvs_next = b_mag;
            cnt_next = req.want_rem ? 6'd32 : 6'd48;
            busy_next = 1'b1;
            neg_q_next = req.dividend[31] ^ req.divisor[31];
            neg_r_next = req.dividend[31];
            rem_mode_next = req.want_rem;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                done = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                if (!trial[32])
                begin
                    rem_next = trial;
                    quot_next = {quot_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], quot_reg[47]};
                    quot_next = {quot_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
        end
        qv = quot_reg;
        rv = rem_reg[31:0];
        if (rem_mode_reg)
            result = neg_r_reg ? (~rv + 32'd1) : rv;
        else if (neg_q_reg)
            result = (qv > 48'h0000_8000_0000) ? 32'h8000_0000 : (~qv[31:0] + 32'd1);
        else
            result = (qv > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : qv[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        rem_mode_reg <= rem_mode_next;
    end

endmodule

@@ hdl/rpn_stack_ram.sv @@
// Stack memory: one write port, one registered read port.
// Uses rpn_pkg for depth and address width.
module rpn_stack_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [rpn_pkg::ADDR_W-1:0]  waddr,
    input  logic [31:0]                 wdata,
    input  logic [rpn_pkg::ADDR_W-1:0]  raddr,
    output logic [31:0]                 rdata
);

    logic [31:0] mem [rpn_pkg::STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
